### sv/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the ray/triangle hit test pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

	localparam int FIELD_W  = 60;
	localparam int EPS_W    = 40;
	localparam int TOL_W    = 16;
	localparam int EPS_FRAC = 36;
	localparam int TOL_FRAC = 16;
	localparam int CFG_DW   = 40;

	localparam logic [EPS_W-1:0] DET_EPS_RST  = 40'd687195;
	localparam logic [TOL_W-1:0] BARY_TOL_RST = 16'd66;

	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_PARALLEL = 2'd1,
		OUT_BARY     = 2'd2,
		OUT_SIDE     = 2'd3
	} outcome_t;

	typedef enum logic {
		CFG_DET_EPS  = 1'b0,
		CFG_BARY_TOL = 1'b1
	} cfg_idx_t;

endpackage

### sv/rth_if.sv
// ----------------------------------------------------------------------------
// rth_if
// Valid/ready channels: ray plus triangle in, hit result out.
// ----------------------------------------------------------------------------
interface rth_ray_if import rth_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] ray_origin;
	logic [FIELD_W-1:0] ray_far_end;
	logic [FIELD_W-1:0] vertex_a;
	logic [FIELD_W-1:0] vertex_b;
	logic [FIELD_W-1:0] vertex_c;

	modport source (output valid, ray_origin, ray_far_end, vertex_a, vertex_b, vertex_c,
		input ready);
	modport sink (input valid, ray_origin, ray_far_end, vertex_a, vertex_b, vertex_c,
		output ready);
endinterface

interface rth_hit_if import rth_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FIELD_W-1:0] hit_point;
	logic [1:0]         outcome;

	modport source (output valid, hit, hit_point, outcome, input ready);
	modport sink (input valid, hit, hit_point, outcome, output ready);
endinterface

### sv/ray_triangle_hit_test_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_hit_test_top
// Fixed-point Moller-Trumbore ray/triangle test with hit point output.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  ray     | in  | valid/ready      | ray_origin, ray_far_end, vertex_a/b/c
//  res     | out | valid/ready      | hit, hit_point, outcome
//  cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// One beat per cycle while res is not stalled; the pipeline depth is set by
// the one-bit-per-stage restoring divider for the hit offset.
// arst_n clears valid bits and loads the register reset values.
// Each stage holds on stall and bubbles collapse; ray.ready drops only when
// every stage is full and res is stalled.
// ----------------------------------------------------------------------------
module ray_triangle_hit_test_top import rth_pkg::*; #(
	parameter int COORD_BITS = 20,
	parameter int FRAC_BITS  = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	rth_ray_if.sink           ray,
	rth_hit_if.source         res
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int CW = 2 * DW + 1;
	localparam int PW = DW + CW + 2;
	localparam int SW = PW + 1;
	localparam int BW = SW + TOL_FRAC + 2;
	localparam int F3 = 3 * FRAC_BITS;
	localparam int EL = (F3 <= EPS_FRAC) ? EPS_FRAC - F3 : 0;
	localparam int ER = (F3 > EPS_FRAC) ? F3 - EPS_FRAC : 0;
	localparam int EW = PW + EPS_W + EL + ER;
	localparam int TL = SW / 2;
	localparam int TH = SW - TL;
	localparam int NW = DW + SW + 1;
	localparam int QB = CB + 1;
	localparam int L  = 9 + QB;
	localparam logic signed [CB+2:0] CMAX = (CB+3)'((64'd1 << (CB - 1)) - 64'd1);
	localparam logic signed [CB+2:0] CMIN = -CMAX - (CB+3)'(1);
	localparam logic [QB-1:0] OFF_LIM = QB'(1) << CB;

	// config
	logic [EPS_W-1:0] det_eps_q;
	logic [TOL_W-1:0] bary_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q  <= DET_EPS_RST;
			bary_tol_q <= BARY_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DET_EPS:  det_eps_q  <= cfg_data[EPS_W-1:0];
				CFG_BARY_TOL: bary_tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// valid chain and per-stage load enables
	logic [L:1]   vld_s;
	logic [L+1:1] ld;

	always_comb begin
		ld[L+1] = res.ready;
		for (int k = L; k >= 1; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	assign ray.ready = ld[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[1]) begin
				vld_s[1] <= ray.valid;
			end
			for (int k = 2; k <= L; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: unpack, edge and direction vectors
	logic [63:0] wo, we, wa, wb, wc;
	logic signed [CB-1:0] uo [3], ue [3], ua [3], ub [3], uc [3];

	assign wo = 64'(ray.ray_origin);
	assign we = 64'(ray.ray_far_end);
	assign wa = 64'(ray.vertex_a);
	assign wb = 64'(ray.vertex_b);
	assign wc = 64'(ray.vertex_c);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			uo[k] = $signed(wo[k*CB +: CB]);
			ue[k] = $signed(we[k*CB +: CB]);
			ua[k] = $signed(wa[k*CB +: CB]);
			ub[k] = $signed(wb[k*CB +: CB]);
			uc[k] = $signed(wc[k*CB +: CB]);
		end
	end

	logic signed [DW-1:0] e1_s1 [3], e2_s1 [3], dir_s1 [3], tv_s1 [3];
	logic signed [CB-1:0] org_s1 [3];

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k]  <= DW'(ub[k]) - DW'(ua[k]);
				e2_s1[k]  <= DW'(uc[k]) - DW'(ua[k]);
				dir_s1[k] <= DW'(uo[k]) - DW'(ue[k]);
				tv_s1[k]  <= DW'(uo[k]) - DW'(ua[k]);
				org_s1[k] <= uo[k];
			end
		end
	end

	// stage 2: cross products
	logic signed [2*DW-1:0] pa [3], pb [3], qa [3], qb [3];

	genvar gk;
	generate
		for (gk = 0; gk < 3; gk++) begin : g_cross
			assign pa[gk] = dir_s1[(gk+1)%3] * e2_s1[(gk+2)%3];
			assign pb[gk] = dir_s1[(gk+2)%3] * e2_s1[(gk+1)%3];
			assign qa[gk] = tv_s1[(gk+1)%3] * e1_s1[(gk+2)%3];
			assign qb[gk] = tv_s1[(gk+2)%3] * e1_s1[(gk+1)%3];
		end
	endgenerate

	logic signed [CW-1:0] pv_s2 [3], qv_s2 [3];
	logic signed [DW-1:0] e1_s2 [3], e2_s2 [3], dir_s2 [3], tv_s2 [3];
	logic signed [CB-1:0] org_s2 [3];

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int k = 0; k < 3; k++) begin
				pv_s2[k]  <= CW'(pa[k]) - CW'(pb[k]);
				qv_s2[k]  <= CW'(qa[k]) - CW'(qb[k]);
				e1_s2[k]  <= e1_s1[k];
				e2_s2[k]  <= e2_s1[k];
				dir_s2[k] <= dir_s1[k];
				tv_s2[k]  <= tv_s1[k];
				org_s2[k] <= org_s1[k];
			end
		end
	end

	// stage 3: determinant and barycentric/distance numerators
	logic signed [PW-1:0] det_n, u_n, v_n, t_n;

	rth_dot3 #(.AW(DW), .BW(CW), .OW(PW)) u_dot_det (.a(e1_s2),  .b(pv_s2), .y(det_n));
	rth_dot3 #(.AW(DW), .BW(CW), .OW(PW)) u_dot_u   (.a(tv_s2),  .b(pv_s2), .y(u_n));
	rth_dot3 #(.AW(DW), .BW(CW), .OW(PW)) u_dot_v   (.a(dir_s2), .b(qv_s2), .y(v_n));
	rth_dot3 #(.AW(DW), .BW(CW), .OW(PW)) u_dot_t   (.a(e2_s2),  .b(qv_s2), .y(t_n));

	logic signed [PW-1:0] det_s3, u_s3, v_s3, t_s3;
	logic signed [DW-1:0] dir_s3 [3];
	logic signed [CB-1:0] org_s3 [3];

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			det_s3 <= det_n;
			u_s3   <= u_n;
			v_s3   <= v_n;
			t_s3   <= t_n;
			dir_s3 <= dir_s2;
			org_s3 <= org_s2;
		end
	end

	// stage 4: make determinant positive
	logic                 dneg;
	logic [PW-1:0]        det_s4;
	logic signed [SW-1:0] u_s4, v_s4, t_s4;
	logic signed [DW-1:0] dir_s4 [3];
	logic signed [CB-1:0] org_s4 [3];

	assign dneg = det_s3[PW-1];

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			det_s4 <= dneg ? PW'(-det_s3) : PW'(det_s3);
			u_s4   <= dneg ? -SW'(u_s3) : SW'(u_s3);
			v_s4   <= dneg ? -SW'(v_s3) : SW'(v_s3);
			t_s4   <= dneg ? -SW'(t_s3) : SW'(t_s3);
			dir_s4 <= dir_s3;
			org_s4 <= org_s3;
		end
	end

	// stage 5: parallel test, barycentric bounds
	logic [EW-1:0]          eps_lhs, eps_rhs;
	logic [PW+TOL_FRAC-1:0] lowb_n;
	logic [PW+TOL_FRAC:0]   highb_n;

	assign eps_lhs = EW'(det_s4) << EL;
	assign eps_rhs = EW'(det_eps_q) << ER;
	assign lowb_n  = det_s4 * bary_tol_q;
	assign highb_n = det_s4 * {1'b1, bary_tol_q};

	logic                   par_s5;
	logic [PW-1:0]          det_s5;
	logic signed [SW-1:0]   u_s5, v_s5, t_s5;
	logic [PW+TOL_FRAC-1:0] lowb_s5;
	logic [PW+TOL_FRAC:0]   highb_s5;
	logic signed [DW-1:0]   dir_s5 [3];
	logic signed [CB-1:0]   org_s5 [3];

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			par_s5   <= (det_s4 == '0) || (eps_lhs < eps_rhs);
			det_s5   <= det_s4;
			u_s5     <= u_s4;
			v_s5     <= v_s4;
			t_s5     <= t_s4;
			lowb_s5  <= lowb_n;
			highb_s5 <= highb_n;
			dir_s5   <= dir_s4;
			org_s5   <= org_s4;
		end
	end

	// stage 6: outcome, partial products of dir * t
	logic signed [BW-1:0] u16, v16, uv16, lo_b, hi_b;
	logic                 bary_bad;
	outcome_t             oc_n;
	logic signed [DW+TL:0]   plo [3];
	logic signed [DW+TH-1:0] phi [3];

	always_comb begin
		u16  = BW'(u_s5) <<< TOL_FRAC;
		v16  = BW'(v_s5) <<< TOL_FRAC;
		uv16 = u16 + v16;
		lo_b = $signed(BW'(lowb_s5));
		hi_b = $signed(BW'(highb_s5));
		bary_bad = ((u16 + lo_b) < 0) || (hi_b < u16) ||
			((v16 + lo_b) < 0) || (hi_b < uv16);
		if (par_s5) begin
			oc_n = OUT_PARALLEL;
		end else if (bary_bad) begin
			oc_n = OUT_BARY;
		end else if (!t_s5[SW-1]) begin
			oc_n = OUT_SIDE;
		end else begin
			oc_n = OUT_HIT;
		end
		for (int k = 0; k < 3; k++) begin
			plo[k] = dir_s5[k] * $signed({1'b0, t_s5[TL-1:0]});
			phi[k] = dir_s5[k] * $signed(t_s5[SW-1:TL]);
		end
	end

	outcome_t                oc_s6;
	logic [PW-1:0]           det_s6;
	logic signed [DW+TL:0]   plo_s6 [3];
	logic signed [DW+TH-1:0] phi_s6 [3];
	logic signed [CB-1:0]    org_s6 [3];

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			oc_s6  <= oc_n;
			det_s6 <= det_s5;
			plo_s6 <= plo;
			phi_s6 <= phi;
			org_s6 <= org_s5;
		end
	end

	// stage 7: rounded dividend magnitude
	logic signed [NW-1:0] num [3];
	logic [NW-1:0]        mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = (NW'(phi_s6[k]) <<< TL) + NW'(plo_s6[k]);
			mag[k] = num[k][NW-1] ? NW'(-num[k]) : NW'(num[k]);
		end
	end

	outcome_t             oc_s7;
	logic [PW-1:0]        det_s7;
	logic [NW-1:0]        n_s7 [3];
	logic                 neg_s7 [3];
	logic signed [CB-1:0] org_s7 [3];

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			oc_s7  <= oc_s6;
			det_s7 <= det_s6;
			org_s7 <= org_s6;
			for (int k = 0; k < 3; k++) begin
				n_s7[k]   <= mag[k] + NW'(det_s6 >> 1);
				neg_s7[k] <= num[k][NW-1];
			end
		end
	end

	// stage 8 and divider stages: index 0 is stage 8, index j is stage 8+j
	outcome_t             oc_sdiv  [QB+1];
	logic [PW-1:0]        det_sdiv [QB+1];
	logic [NW-1:0]        rem_sdiv [QB+1][3];
	logic [QB-1:0]        quo_sdiv [QB+1][3];
	logic                 neg_sdiv [QB+1][3];
	logic                 ovf_sdiv [QB+1][3];
	logic signed [CB-1:0] org_sdiv [QB+1][3];

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			oc_sdiv[0]  <= oc_s7;
			det_sdiv[0] <= det_s7;
			org_sdiv[0] <= org_s7;
			for (int k = 0; k < 3; k++) begin
				rem_sdiv[0][k] <= n_s7[k];
				quo_sdiv[0][k] <= '0;
				neg_sdiv[0][k] <= neg_s7[k];
				ovf_sdiv[0][k] <= n_s7[k] >= NW'({det_s7, {QB{1'b0}}});
			end
		end
	end

	genvar gj;
	generate
		for (gj = 1; gj <= QB; gj++) begin : g_div
			logic [NW-1:0] dsh;
			assign dsh = NW'(det_sdiv[gj-1]) << (QB - gj);

			always_ff @(posedge clk) begin
				if (ld[8+gj]) begin
					oc_sdiv[gj]  <= oc_sdiv[gj-1];
					det_sdiv[gj] <= det_sdiv[gj-1];
					org_sdiv[gj] <= org_sdiv[gj-1];
					for (int k = 0; k < 3; k++) begin
						neg_sdiv[gj][k] <= neg_sdiv[gj-1][k];
						ovf_sdiv[gj][k] <= ovf_sdiv[gj-1][k];
						if (rem_sdiv[gj-1][k] >= dsh) begin
							rem_sdiv[gj][k] <= rem_sdiv[gj-1][k] - dsh;
							quo_sdiv[gj][k] <= quo_sdiv[gj-1][k] | (QB'(1) << (QB - gj));
						end else begin
							rem_sdiv[gj][k] <= rem_sdiv[gj-1][k];
							quo_sdiv[gj][k] <= quo_sdiv[gj-1][k];
						end
					end
				end
			end
		end
	endgenerate

	// output stage: clamp offset, add, saturate
	logic [QB-1:0]        off [3];
	logic signed [CB+2:0] sum [3];
	logic signed [CB+2:0] sat [3];
	logic [63:0]          pt;

	always_comb begin
		pt = '0;
		for (int k = 0; k < 3; k++) begin
			off[k] = (ovf_sdiv[QB][k] || quo_sdiv[QB][k] > OFF_LIM) ? OFF_LIM
				: quo_sdiv[QB][k];
			sum[k] = (CB+3)'(org_sdiv[QB][k]) + (neg_sdiv[QB][k]
				? -$signed({2'b00, off[k]}) : $signed({2'b00, off[k]}));
			if (sum[k] > CMAX) begin
				sat[k] = CMAX;
			end else if (sum[k] < CMIN) begin
				sat[k] = CMIN;
			end else begin
				sat[k] = sum[k];
			end
			pt[k*CB +: CB] = sat[k][CB-1:0];
		end
	end

	logic               hit_q;
	logic [FIELD_W-1:0] point_q;
	outcome_t           oc_q;

	always_ff @(posedge clk) begin
		if (ld[L]) begin
			hit_q   <= oc_sdiv[QB] == OUT_HIT;
			point_q <= (oc_sdiv[QB] == OUT_HIT) ? pt[FIELD_W-1:0] : '0;
			oc_q    <= oc_sdiv[QB];
		end
	end

	assign res.valid     = vld_s[L];
	assign res.hit       = hit_q;
	assign res.hit_point = point_q;
	assign res.outcome   = oc_q;

`ifndef SYNTH
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.hit == (res.outcome == OUT_HIT)))
		else $error("hit flag disagrees with outcome");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.hit_point == '0)
		else $error("miss beat carries a nonzero point");

	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[L] |-> ray.ready)
		else $error("input stalled with empty output stage");

	a_zero_det: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] && det_s5 == '0 |-> par_s5)
		else $error("zero determinant not flagged parallel");
`endif

endmodule

### sv/rth_dot3.sv
// ----------------------------------------------------------------------------
// rth_dot3
// Exact signed three-term dot product.
// ----------------------------------------------------------------------------
module rth_dot3 import rth_pkg::*; #(
	parameter int AW = 21,
	parameter int BW = 43,
	parameter int OW = 66
) (
	input  logic signed [AW-1:0] a [3],
	input  logic signed [BW-1:0] b [3],
	output logic signed [OW-1:0] y
);

	logic signed [AW+BW-1:0] p [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p[k] = a[k] * b[k];
		end
		y = OW'(p[0]) + OW'(p[1]) + OW'(p[2]);
	end

endmodule
